FILE: rtl/core/rgbilc_pkg.sv
// Shared types, constants and helpers for the RGB indicator light controller.
// Used by the top level and by its port checker; no dependencies.

package rgbilc_pkg;

    localparam int RAMP_ENTRIES    = 8;
    localparam int NOMINAL_STEP_MS = 50;
    localparam int RAMP_TAB_SIZE   = 8;
    localparam int RAMP_BEATS      = (RAMP_ENTRIES > RAMP_TAB_SIZE) ? RAMP_TAB_SIZE : RAMP_ENTRIES;
    localparam int STEP_DIV        = 2 * RAMP_ENTRIES;
    localparam int SPAN_MS         = NOMINAL_STEP_MS * STEP_DIV;
    localparam int NUM_SOURCES     = 3;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 2;
    localparam int LEVEL_W     = 12;

    // m_tdata field positions
    localparam int OUT_COLOR_LSB = 12;
    localparam int OUT_INDEX_LSB = 36;
    localparam int OUT_EN_BIT    = 39;

    localparam logic [2:0]         LAST_IDX        = 3'(RAMP_BEATS - 1);
    localparam logic [1:0]         FLASH_TIMED     = 2'd1;
    localparam logic [LEVEL_W-1:0] PANEL_MAX_RESET = 12'd255;

    localparam logic [1:0] SRC_ATTENTION    = 2'd0;
    localparam logic [1:0] SRC_BATTERY      = 2'd1;
    localparam logic [1:0] SRC_NOTIFICATION = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_BACKLIGHT    = 2'd0,
        OP_ATTENTION    = 2'd1,
        OP_BATTERY      = 2'd2,
        OP_NOTIFICATION = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_BACKLIGHT = 2'd0,
        KIND_STEADY    = 2'd1,
        KIND_OFF       = 2'd2,
        KIND_RAMP      = 2'd3
    } kind_t;

    // Ramp brightness profile, percent-like scale
    function automatic logic [6:0] ramp_value(input logic [2:0] idx);
        logic [6:0] v;
        case (idx)
            3'd0:    v = 7'd0;
            3'd1:    v = 7'd12;
            3'd2:    v = 7'd25;
            3'd3:    v = 7'd37;
            3'd4:    v = 7'd50;
            3'd5:    v = 7'd72;
            3'd6:    v = 7'd85;
            3'd7:    v = 7'd100;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    // x / 255 for x < 255*4096 (12-bit result): series estimate, then one +/-1 fix-up
    function automatic logic [11:0] div255(input logic [19:0] x);
        logic [20:0] xe;
        logic [20:0] est;
        logic [12:0] q;
        logic [20:0] qm;
        xe  = {1'b0, x};
        est = xe + {9'h000, x[19:8]} + {17'h00000, x[19:16]} + 21'd1;
        q   = est[20:8];
        qm  = {q, 8'h00} - {8'h00, q};
        if (qm > xe) begin
            q = q - 13'd1;
        end else if ((xe - qm) >= 21'd255) begin
            q = q + 13'd1;
        end
        return q[11:0];
    endfunction

endpackage

FILE: rtl/core/rgb_indicator_light_controller_top.sv
// RGB indicator light controller: request pipeline, source store, beat generator.
// Depends on rgbilc_pkg.
//
// Usage:
//   s_ channel: one beat per light request. s_tuser = op, s_tdata = color,
//   flash mode, on and off times. m_ channel: result beats, m_tuser = kind,
//   m_tlast on the final beat of a request. cfg_ channel writes the panel
//   maximum brightness; cfg_ready is always high, write only while idle.
//   The first result beat passes the input, generator, product and output
//   registers in that order after the request beat is accepted.
//   Throughput: backlight, steady and off requests give one beat each and a
//   new request is taken every cycle while m_tready is high. A timed blink
//   gives 8 ramp beats, one per cycle from the ramp counter while m_tready
//   is high, and occupies the beat generator; the input register takes one
//   more request, then holds s_tready low until its last ramp beat leaves.
//   Reset clears all three indicator sources (unlit), the pipeline valids and
//   sets the panel maximum to 255. When m_tready is low the output register
//   holds its beat and the stall backs up stage by stage to s_tready.

module rgb_indicator_light_controller_top
    import rgbilc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [31:0] argb_color, [33:32] flash_mode, [49:34] on_time_ms,
    // [65:50] off_time_ms, [71:66] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] op
    input  logic [OP_W-1:0]        s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [11:0] backlight_level, [19:12] red_value, [27:20] green_value,
    // [35:28] blue_value, [38:36] ramp_index, [39] blink_enable,
    // [55:40] pause_low_ms, [71:56] pause_high_ms, [77:72] step_ms, [79:78] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [1:0] kind
    output logic [KIND_W-1:0]      m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LEVEL_W-1:0]     cfg_data
);

    // ---------------- config ----------------
    logic [LEVEL_W-1:0] pm_reg;

    assign cfg_ready = 1'b1;

    // ---------------- input stage ----------------
    logic [7:0]  in_r, in_g, in_b, in_a;
    logic [15:0] in_luma_sum;
    logic [15:0] in_pr, in_pg, in_pb;

    logic        a_valid_reg;
    op_t         a_op_reg;
    logic [7:0]  a_luma_reg;
    logic [23:0] a_rgb_reg;
    logic [7:0]  a_alpha_reg;
    logic [15:0] a_pr_reg, a_pg_reg, a_pb_reg;
    logic        a_timed_reg;
    logic [15:0] a_on_reg, a_off_reg;
    logic        a_take;

    assign in_a = s_tdata[31:24];
    assign in_r = s_tdata[23:16];
    assign in_g = s_tdata[15:8];
    assign in_b = s_tdata[7:0];

    assign in_luma_sum = 16'd77 * {8'h00, in_r} + 16'd150 * {8'h00, in_g}
                       + 16'd29 * {8'h00, in_b};
    assign in_pr = {8'h00, in_r} * {8'h00, in_a};
    assign in_pg = {8'h00, in_g} * {8'h00, in_a};
    assign in_pb = {8'h00, in_b} * {8'h00, in_a};

    assign s_tready = !a_valid_reg || a_take;

    // ---------------- source store and LED select ----------------
    logic [23:0] src_color_reg [NUM_SOURCES];
    logic        src_timed_reg [NUM_SOURCES];
    logic [15:0] src_on_reg    [NUM_SOURCES];
    logic [15:0] src_off_reg   [NUM_SOURCES];
    logic [23:0] src_color_next [NUM_SOURCES];
    logic        src_timed_next [NUM_SOURCES];
    logic [15:0] src_on_next    [NUM_SOURCES];
    logic [15:0] src_off_next   [NUM_SOURCES];

    logic [11:0] dr, dg, db;
    logic        alpha_scale;
    logic [23:0] new_color;
    logic [1:0]  slot;
    logic [1:0]  sel;
    logic        any_lit;
    logic [23:0] sel_color;
    logic [15:0] sel_on, sel_off;
    logic        sel_blink;
    kind_t       a_kind;
    logic [5:0]  a_step;
    logic [15:0] a_phi;
    logic [19:0] a_lvl_prod;

    assign dr = div255({4'h0, a_pr_reg});
    assign dg = div255({4'h0, a_pg_reg});
    assign db = div255({4'h0, a_pb_reg});

    assign alpha_scale = (a_op_reg == OP_NOTIFICATION) && (a_alpha_reg != 8'h00)
                      && (a_alpha_reg != 8'hff);
    assign new_color = alpha_scale ? {dr[7:0], dg[7:0], db[7:0]} : a_rgb_reg;

    always_comb begin
        case (a_op_reg)
            OP_ATTENTION: slot = SRC_ATTENTION;
            OP_BATTERY:   slot = SRC_BATTERY;
            default:      slot = SRC_NOTIFICATION;
        endcase
    end

    always_comb begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
            src_color_next[i] = src_color_reg[i];
            src_timed_next[i] = src_timed_reg[i];
            src_on_next[i]    = src_on_reg[i];
            src_off_next[i]   = src_off_reg[i];
        end
        if (a_valid_reg && a_op_reg != OP_BACKLIGHT) begin
            src_color_next[slot] = new_color;
            src_timed_next[slot] = a_timed_reg;
            src_on_next[slot]    = a_on_reg;
            src_off_next[slot]   = a_off_reg;
        end
    end

    // priority: notification, attention, battery (against post-write state)
    always_comb begin
        any_lit = 1'b1;
        if (src_color_next[SRC_NOTIFICATION] != 24'h0) begin
            sel = SRC_NOTIFICATION;
        end else if (src_color_next[SRC_ATTENTION] != 24'h0) begin
            sel = SRC_ATTENTION;
        end else begin
            sel     = SRC_BATTERY;
            any_lit = (src_color_next[SRC_BATTERY] != 24'h0);
        end
    end

    assign sel_color = src_color_next[sel];
    assign sel_on    = src_timed_next[sel] ? src_on_next[sel] : 16'h0000;
    assign sel_off   = src_timed_next[sel] ? src_off_next[sel] : 16'h0000;
    assign sel_blink = (sel_on != 16'h0000) && (sel_off != 16'h0000);

    always_comb begin
        if (a_op_reg == OP_BACKLIGHT) begin
            a_kind = KIND_BACKLIGHT;
        end else if (!any_lit) begin
            a_kind = KIND_OFF;
        end else if (sel_blink) begin
            a_kind = KIND_RAMP;
        end else begin
            a_kind = KIND_STEADY;
        end
    end

    // short on time: shrink the step, no high pause
    always_comb begin
        if (sel_on < 16'(SPAN_MS)) begin
            a_step = 6'(sel_on / STEP_DIV);
            a_phi  = 16'h0000;
        end else begin
            a_step = 6'(NOMINAL_STEP_MS);
            a_phi  = sel_on - 16'(SPAN_MS);
        end
    end

    assign a_lvl_prod = {12'h000, a_luma_reg} * {8'h00, pm_reg};

    // ---------------- beat generator ----------------
    logic        g_valid_reg;
    kind_t       g_kind_reg;
    logic [2:0]  g_idx_reg;
    logic [23:0] g_color_reg;
    logic [19:0] g_lvl_prod_reg;
    logic [7:0]  g_luma_reg;
    logic        g_direct_reg;
    logic [15:0] g_off_reg, g_phi_reg;
    logic [5:0]  g_step_reg;
    logic        g_last;
    logic        g_ready;
    logic        g_fire;
    logic [6:0]  g_rv;
    logic [14:0] g_pr, g_pg, g_pb;

    assign g_last  = (g_kind_reg != KIND_RAMP) || (g_idx_reg == LAST_IDX);
    assign g_ready = !g_valid_reg || (g_fire && g_last);
    assign a_take  = a_valid_reg && g_ready;

    assign g_rv = ramp_value(g_idx_reg);
    assign g_pr = {8'h00, g_rv} * {7'h00, g_color_reg[23:16]};
    assign g_pg = {8'h00, g_rv} * {7'h00, g_color_reg[15:8]};
    assign g_pb = {8'h00, g_rv} * {7'h00, g_color_reg[7:0]};

    // ---------------- product stage ----------------
    logic        p_valid_reg;
    kind_t       p_kind_reg;
    logic [23:0] p_rgb_reg;
    logic [14:0] p_pr_reg, p_pg_reg, p_pb_reg;
    logic [19:0] p_lvl_prod_reg;
    logic [7:0]  p_luma_reg;
    logic        p_direct_reg;
    logic [2:0]  p_idx_reg;
    logic [15:0] p_off_reg, p_phi_reg;
    logic [5:0]  p_step_reg;
    logic        p_last_reg;
    logic        p_ready;
    logic        o_ready;

    assign p_ready = !p_valid_reg || o_ready;
    assign g_fire  = g_valid_reg && p_ready;

    // ---------------- output stage ----------------
    logic                   o_load;
    logic                   o_valid_reg;
    logic [OUT_TDATA_W-1:0] o_tdata_reg;
    kind_t                  o_kind_reg;
    logic                   o_last_reg;
    logic [11:0]            o_lvl_div, o_rd, o_gd, o_bd;
    logic [OUT_TDATA_W-1:0] o_tdata_next;

    assign o_ready = !o_valid_reg || m_tready;
    assign o_load  = p_valid_reg && o_ready;

    assign o_lvl_div = div255(p_lvl_prod_reg);
    assign o_rd      = div255({5'h00, p_pr_reg});
    assign o_gd      = div255({5'h00, p_pg_reg});
    assign o_bd      = div255({5'h00, p_pb_reg});

    always_comb begin
        o_tdata_next = '0;
        case (p_kind_reg)
            KIND_BACKLIGHT: begin
                o_tdata_next[11:0] = p_direct_reg ? {4'h0, p_luma_reg} : o_lvl_div;
            end
            KIND_STEADY: begin
                o_tdata_next[35:12] = {p_rgb_reg[7:0], p_rgb_reg[15:8], p_rgb_reg[23:16]};
            end
            KIND_RAMP: begin
                o_tdata_next[35:12] = {o_bd[7:0], o_gd[7:0], o_rd[7:0]};
                o_tdata_next[38:36] = p_idx_reg;
                o_tdata_next[39]    = 1'b1;
                o_tdata_next[55:40] = p_off_reg;
                o_tdata_next[71:56] = p_phi_reg;
                o_tdata_next[77:72] = p_step_reg;
            end
            default: begin
                o_tdata_next = '0;
            end
        endcase
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_tdata_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pm_reg      <= PANEL_MAX_RESET;
            a_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            g_idx_reg   <= 3'd0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                src_color_reg[i] <= 24'h0;
                src_timed_reg[i] <= 1'b0;
                src_on_reg[i]    <= 16'h0;
                src_off_reg[i]   <= 16'h0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                pm_reg <= cfg_data;
            end
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            if (a_take) begin
                for (int i = 0; i < NUM_SOURCES; i++) begin
                    src_color_reg[i] <= src_color_next[i];
                    src_timed_reg[i] <= src_timed_next[i];
                    src_on_reg[i]    <= src_on_next[i];
                    src_off_reg[i]   <= src_off_next[i];
                end
            end
            if (a_take) begin
                g_valid_reg <= 1'b1;
                g_idx_reg   <= 3'd0;
            end else if (g_fire) begin
                if (g_last) begin
                    g_valid_reg <= 1'b0;
                end else begin
                    g_idx_reg <= g_idx_reg + 3'd1;
                end
            end
            if (p_ready) begin
                p_valid_reg <= g_valid_reg;
            end
            if (o_ready) begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_op_reg    <= op_t'(s_tuser);
            a_luma_reg  <= in_luma_sum[15:8];
            a_rgb_reg   <= s_tdata[23:0];
            a_alpha_reg <= in_a;
            a_pr_reg    <= in_pr;
            a_pg_reg    <= in_pg;
            a_pb_reg    <= in_pb;
            a_timed_reg <= (s_tdata[33:32] == FLASH_TIMED);
            a_on_reg    <= s_tdata[49:34];
            a_off_reg   <= s_tdata[65:50];
        end
        if (a_take) begin
            g_kind_reg     <= a_kind;
            g_color_reg    <= sel_color;
            g_lvl_prod_reg <= a_lvl_prod;
            g_luma_reg     <= a_luma_reg;
            g_direct_reg   <= (pm_reg == PANEL_MAX_RESET);
            g_off_reg      <= sel_off;
            g_phi_reg      <= a_phi;
            g_step_reg     <= a_step;
        end
        if (g_fire) begin
            p_kind_reg     <= g_kind_reg;
            p_rgb_reg      <= g_color_reg;
            p_pr_reg       <= g_pr;
            p_pg_reg       <= g_pg;
            p_pb_reg       <= g_pb;
            p_lvl_prod_reg <= g_lvl_prod_reg;
            p_luma_reg     <= g_luma_reg;
            p_direct_reg   <= g_direct_reg;
            p_idx_reg      <= g_idx_reg;
            p_off_reg      <= g_off_reg;
            p_phi_reg      <= g_phi_reg;
            p_step_reg     <= g_step_reg;
            p_last_reg     <= g_last;
        end
        if (o_load) begin
            o_tdata_reg <= o_tdata_next;
            o_kind_reg  <= p_kind_reg;
            o_last_reg  <= p_last_reg;
        end
    end

endmodule

FILE: rtl/core/rgbilc_checker.sv
// Port-level checks on the result channel of the RGB indicator light controller.
// Depends on rgbilc_pkg; bound to rgb_indicator_light_controller_top below.

module rgbilc_checker
    import rgbilc_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]      m_tuser,
    input logic                   m_tlast
);

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result beat changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_single_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_RAMP |-> m_tlast)
        else $error("non-ramp result not marked last");

    a_ramp_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_RAMP
        |-> (m_tlast == (m_tdata[OUT_INDEX_LSB +: 3] == LAST_IDX)) && m_tdata[OUT_EN_BIT])
        else $error("ramp beat last flag or enable wrong");

    // ramp beats count up without gaps
    a_ramp_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == KIND_RAMP && !m_tlast
        |=> !m_tvalid || (m_tuser == KIND_RAMP
        && m_tdata[OUT_INDEX_LSB +: 3] == $past(m_tdata[OUT_INDEX_LSB +: 3]) + 3'd1))
        else $error("ramp index out of sequence");

endmodule

bind rgb_indicator_light_controller_top rgbilc_checker u_rgbilc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
